// ----- rtl/fwst_pkg.sv -----
// Shared types and constants for the futex wait slot table.
`timescale 1ns / 1ps
`default_nettype none

package fwst_pkg;

    localparam int SLOT_COUNT_DEF = 64;
    localparam int KIND_W         = 2;
    localparam int ADDR_W         = 64;
    localparam int IDX_W          = 6;
    localparam int CNT_W          = 32;
    localparam int GEN_W          = 32;
    localparam int STATUS_W       = 2;
    localparam int ENTRY_W        = ADDR_W + CNT_W + GEN_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENTER = 2'd0,
        KIND_POLL  = 2'd1,
        KIND_LEAVE = 2'd2,
        KIND_WAKE  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] key;
        logic [CNT_W-1:0]  count;
        logic [GEN_W-1:0]  gen;
    } entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic rd;
        logic capture;
        logic commit;
        logic out_load;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clear_last;
        logic go_scan;
        logic go_read;
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/fwst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fwst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/fwst_ctrl.sv -----
// Controller state machine for the futex wait slot table.
`timescale 1ns / 1ps
`default_nettype none

module fwst_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire fwst_pkg::sts_t sts,
    output fwst_pkg::cmd_t      cmd
);

    import fwst_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DISP  = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_RD    = 8'b0001_0000,
        S_CHK   = 8'b0010_0000,
        S_WR    = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.go_scan)
                begin
                    state_next = S_SCAN;
                end
                else if (sts.go_read)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_WR;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.capture = 1'b1;
                state_next  = S_WR;
            end
            S_WR:
            begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/fwst_dp.sv -----
// Datapath for the futex wait slot table: slot store, scan, update and result beat.
`timescale 1ns / 1ps
`default_nettype none

module fwst_dp #(
    parameter int SLOT_COUNT = fwst_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [fwst_pkg::KIND_W-1:0]   kind,
    input  wire logic [fwst_pkg::ADDR_W-1:0]   word_address,
    input  wire logic [fwst_pkg::IDX_W-1:0]    slot_index,
    input  wire logic [fwst_pkg::CNT_W-1:0]    wake_limit,
    input  wire fwst_pkg::cmd_t                cmd,
    output fwst_pkg::sts_t                     sts,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [fwst_pkg::STATUS_W-1:0] status,
    output logic      [fwst_pkg::IDX_W-1:0]    slot_found,
    output logic      [fwst_pkg::GEN_W-1:0]    generation,
    output logic      [fwst_pkg::CNT_W-1:0]    released
);

    import fwst_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int IW = AW + IDX_W + 1;
    localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

    // Captured request
    kind_t              kind_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [AW-1:0]      idx_reg;
    logic               idx_ok_reg;
    logic [CNT_W-1:0]   limit_reg;

    // Scan and clear control
    logic [AW-1:0]      clr_ptr_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic               issued_all_reg;
    logic               cmp_valid_reg;
    logic [AW-1:0]      cmp_ptr_reg;
    logic               hit_reg;
    logic [AW-1:0]      hit_ptr_reg;
    logic               free_reg;
    logic [AW-1:0]      free_ptr_reg;
    entry_t             ent_reg;

    // Result beat
    logic               out_valid_reg;
    status_t            status_reg;
    logic [IDX_W-1:0]   found_reg;
    logic [GEN_W-1:0]   gen_reg;
    logic [CNT_W-1:0]   rel_reg;

    logic [IW-1:0]      idx_wide;
    logic [IW-1:0]      hit_wide;
    logic [IW-1:0]      free_wide;
    logic               idx_ok;
    logic               addr_zero;
    logic               scan_issue;
    logic               key_hit;
    logic               key_free;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_ent;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic               wr_need;
    logic [AW-1:0]      wr_ptr;
    entry_t             wr_ent;
    status_t            res_status;
    logic [IDX_W-1:0]   res_found;
    logic [GEN_W-1:0]   res_gen;
    logic [CNT_W-1:0]   res_rel;

    assign idx_wide   = IW'(slot_index);
    assign idx_ok     = idx_wide < IW'(SLOT_COUNT);
    assign hit_wide   = IW'(hit_ptr_reg);
    assign free_wide  = IW'(free_ptr_reg);
    assign addr_zero  = (addr_reg == '0);
    assign rd_ent     = entry_t'(ram_rdata);
    assign key_hit    = (rd_ent.key == addr_reg);
    assign key_free   = (rd_ent.key == '0);
    assign scan_issue = cmd.scan && !issued_all_reg;

    assign sts.clear_last = (clr_ptr_reg == LAST);
    assign sts.go_scan    = !addr_zero
                            && ((kind_reg == KIND_ENTER)
                                || ((kind_reg == KIND_WAKE) && (limit_reg != '0)));
    assign sts.go_read    = ((kind_reg == KIND_POLL) || (kind_reg == KIND_LEAVE))
                            && idx_ok_reg;
    assign sts.scan_done  = cmp_valid_reg && (key_hit || (cmp_ptr_reg == LAST));
    assign sts.out_free   = !out_valid_reg || out_ready;

    fwst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_we    = cmd.clear || (cmd.commit && wr_need);
    assign ram_waddr = cmd.clear ? clr_ptr_reg : wr_ptr;
    assign ram_wdata = cmd.clear ? '0 : ENTRY_W'(wr_ent);
    assign ram_raddr = cmd.rd ? idx_reg : rd_ptr_reg;

    // Slot update for the read-modify-write step
    always_comb
    begin
        wr_need = 1'b0;
        wr_ptr  = hit_ptr_reg;
        wr_ent  = ent_reg;
        case (kind_reg)
            KIND_ENTER:
            begin
                if (!addr_zero)
                begin
                    if (hit_reg)
                    begin
                        wr_need = 1'b1;
                        if (ent_reg.count != '1)
                        begin
                            wr_ent.count = ent_reg.count + CNT_W'(1);
                        end
                    end
                    else if (free_reg)
                    begin
                        wr_need      = 1'b1;
                        wr_ptr       = free_ptr_reg;
                        wr_ent.key   = addr_reg;
                        wr_ent.count = CNT_W'(1);
                        wr_ent.gen   = GEN_W'(1);
                    end
                end
            end
            KIND_LEAVE:
            begin
                if (hit_reg && (ent_reg.count != '0))
                begin
                    wr_need = 1'b1;
                    if (ent_reg.count == CNT_W'(1))
                    begin
                        wr_ent = '0;
                    end
                    else
                    begin
                        wr_ent.count = ent_reg.count - CNT_W'(1);
                    end
                end
            end
            KIND_WAKE:
            begin
                if (hit_reg && (ent_reg.count != '0))
                begin
                    wr_need    = 1'b1;
                    wr_ent.gen = ent_reg.gen + GEN_W'(1);
                end
            end
            default:
            begin
                wr_need = 1'b0;
            end
        endcase
    end

    // Result fields, from state that holds still after the update step
    always_comb
    begin
        res_status = ST_OK;
        res_found  = '0;
        res_gen    = '0;
        res_rel    = '0;
        case (kind_reg)
            KIND_ENTER:
            begin
                if (addr_zero)
                begin
                    res_status = ST_INVALID;
                end
                else if (hit_reg)
                begin
                    res_found = hit_wide[IDX_W-1:0];
                    res_gen   = ent_reg.gen;
                end
                else if (free_reg)
                begin
                    res_found = free_wide[IDX_W-1:0];
                    res_gen   = GEN_W'(1);
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            KIND_POLL:
            begin
                if (hit_reg)
                begin
                    res_gen = ent_reg.gen;
                end
            end
            KIND_WAKE:
            begin
                if (addr_zero)
                begin
                    res_status = ST_INVALID;
                end
                else if (hit_reg)
                begin
                    res_rel = (limit_reg < ent_reg.count) ? limit_reg : ent_reg.count;
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    // Request capture and entry capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind_t'(kind);
            addr_reg   <= word_address;
            idx_reg    <= idx_wide[AW-1:0];
            idx_ok_reg <= idx_ok;
            limit_reg  <= wake_limit;
        end
        if (cmd.scan)
        begin
            cmp_ptr_reg <= rd_ptr_reg;
            if (cmp_valid_reg && key_hit && !hit_reg)
            begin
                hit_ptr_reg <= cmp_ptr_reg;
                ent_reg     <= rd_ent;
            end
            if (cmp_valid_reg && key_free && !free_reg)
            begin
                free_ptr_reg <= cmp_ptr_reg;
            end
        end
        if (cmd.capture)
        begin
            hit_ptr_reg <= idx_reg;
            ent_reg     <= rd_ent;
        end
        if (cmd.out_load)
        begin
            status_reg <= res_status;
            found_reg  <= res_found;
            gen_reg    <= res_gen;
            rel_reg    <= res_rel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg    <= '0;
            rd_ptr_reg     <= '0;
            issued_all_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_ptr_reg <= (clr_ptr_reg == LAST) ? '0 : clr_ptr_reg + AW'(1);
            end
            if (cmd.load)
            begin
                rd_ptr_reg     <= '0;
                issued_all_reg <= 1'b0;
                cmp_valid_reg  <= 1'b0;
                hit_reg        <= 1'b0;
                free_reg       <= 1'b0;
            end
            if (cmd.scan)
            begin
                // Issue one read per cycle; compare the previous one
                cmp_valid_reg <= scan_issue;
                if (scan_issue)
                begin
                    issued_all_reg <= (rd_ptr_reg == LAST);
                    if (rd_ptr_reg != LAST)
                    begin
                        rd_ptr_reg <= rd_ptr_reg + AW'(1);
                    end
                end
                if (cmp_valid_reg && key_hit)
                begin
                    hit_reg <= 1'b1;
                end
                if (cmp_valid_reg && key_free)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (cmd.capture)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_found = found_reg;
    assign generation = gen_reg;
    assign released   = rel_reg;

endmodule

`default_nettype wire

// ----- rtl/futex_wait_slot_table.sv -----
// Top level of the futex wait slot table.
// Enter and wake search the slot store for the key; poll and leave read the slot at
// slot_index. The scan reads one entry per cycle through the single read port,
// stopping at a match. Zero-address and trivial requests skip the store.
// One request at a time. After reset the store is cleared one slot per cycle, with
// in_ready low. The result beat sits in an output register until taken.
`timescale 1ns / 1ps
`default_nettype none

module futex_wait_slot_table #(
    parameter int SLOT_COUNT = fwst_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [fwst_pkg::KIND_W-1:0]   kind,
    input  wire logic [fwst_pkg::ADDR_W-1:0]   word_address,
    input  wire logic [fwst_pkg::IDX_W-1:0]    slot_index,
    input  wire logic [fwst_pkg::CNT_W-1:0]    wake_limit,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [fwst_pkg::STATUS_W-1:0] status,
    output logic      [fwst_pkg::IDX_W-1:0]    slot_found,
    output logic      [fwst_pkg::GEN_W-1:0]    generation,
    output logic      [fwst_pkg::CNT_W-1:0]    released
);

    import fwst_pkg::*;

    cmd_t cmd;
    sts_t sts;

    fwst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fwst_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .kind         (kind),
        .word_address (word_address),
        .slot_index   (slot_index),
        .wake_limit   (wake_limit),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .slot_found   (slot_found),
        .generation   (generation),
        .released     (released)
    );

endmodule

`default_nettype wire

// ----- bench/tb_futex_wait_slot_table.sv -----
// Self-checking bench for the futex wait slot table: directed, table-full and random traffic.
`timescale 1ns / 1ps

module tb_futex_wait_slot_table;

    import fwst_pkg::*;

    localparam int SLOTS      = SLOT_COUNT_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int POOL_SIZE  = 96;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  slot;
        logic [GEN_W-1:0]  gen;
        logic [CNT_W-1:0]  released;
    } reply_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [KIND_W-1:0]     kind;
    logic [ADDR_W-1:0]     word_address;
    logic [IDX_W-1:0]      slot_index;
    logic [CNT_W-1:0]      wake_limit;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [IDX_W-1:0]      slot_found;
    logic [GEN_W-1:0]      generation;
    logic [CNT_W-1:0]      released;

    // Mirror of the slot store.
    logic [ADDR_W-1:0]     key_mirror   [SLOTS];
    logic [CNT_W-1:0]      count_mirror [SLOTS];
    logic [GEN_W-1:0]      gen_mirror   [SLOTS];

    logic [ADDR_W-1:0]     addr_pool [POOL_SIZE];
    reply_t                expected_replies [$];
    reply_t                oldest_reply;
    bit                    gaps_on;
    int                    bad_count;
    int                    stall_left;
    int                    idle_cycles;

    futex_wait_slot_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .word_address (word_address),
        .slot_index   (slot_index),
        .wake_limit   (wake_limit),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .slot_found   (slot_found),
        .generation   (generation),
        .released     (released)
    );

    always #10 clk = ~clk;

    function automatic int find_slot(input logic [ADDR_W-1:0] key);
        int hit;
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (hit < 0 && key_mirror[i] == key)
                hit = i;
        end
        return hit;
    endfunction

    // Apply one request to the mirror and return the reply it must produce.
    function automatic reply_t apply_request(input kind_t k, input logic [ADDR_W-1:0] a,
                                             input logic [IDX_W-1:0] i,
                                             input logic [CNT_W-1:0] l);
        reply_t       r;
        int           s;
        logic [CNT_W-1:0] waiters;
        r = '0;
        r.status = ST_OK;
        case (k)
            KIND_ENTER:
            begin
                if (a == '0)
                    r.status = ST_INVALID;
                else
                begin
                    s = find_slot(a);
                    if (s < 0)
                    begin
                        s = find_slot('0);
                        if (s >= 0)
                        begin
                            key_mirror[s]   = a;
                            count_mirror[s] = '0;
                            gen_mirror[s]   = 1;
                        end
                    end
                    if (s < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        if (count_mirror[s] != '1)
                            count_mirror[s] = count_mirror[s] + 1;
                        r.slot = s[IDX_W-1:0];
                        r.gen  = gen_mirror[s];
                    end
                end
            end
            KIND_POLL:
            begin
                if (int'(i) < SLOTS)
                    r.gen = gen_mirror[i];
            end
            KIND_LEAVE:
            begin
                if (int'(i) < SLOTS && count_mirror[i] != '0)
                begin
                    count_mirror[i] = count_mirror[i] - 1;
                    if (count_mirror[i] == '0)
                    begin
                        key_mirror[i] = '0;
                        gen_mirror[i] = '0;
                    end
                end
            end
            default:
            begin
                if (a == '0)
                    r.status = ST_INVALID;
                else if (l != '0)
                begin
                    s = find_slot(a);
                    if (s >= 0)
                    begin
                        waiters    = count_mirror[s];
                        r.released = (l < waiters) ? l : waiters;
                        if (waiters != '0)
                            gen_mirror[s] = gen_mirror[s] + 1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] fresh_address();
        logic [ADDR_W-1:0] a;
        do
            a = {$urandom, $urandom};
        while (a == '0 || find_slot(a) >= 0);
        return a;
    endfunction

    function automatic logic [IDX_W-1:0] busy_slot();
        int busy [$];
        for (int i = 0; i < SLOTS; i++)
        begin
            if (count_mirror[i] != '0)
                busy.push_back(i);
        end
        if (busy.size() == 0)
            return IDX_W'($urandom_range(0, SLOTS - 1));
        return IDX_W'(busy[$urandom_range(0, busy.size() - 1)]);
    endfunction

    task automatic send_request(input kind_t k, input logic [ADDR_W-1:0] a,
                                input logic [IDX_W-1:0] i, input logic [CNT_W-1:0] l);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        word_address <= a;
        slot_index   <= i;
        wake_limit   <= l;
        do
            @(posedge clk);
        while (!in_ready);
        expected_replies.push_back(apply_request(k, a, i, l));
    endtask

    // Drop valid and hold until every reply is back.
    task automatic wait_for_replies();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_replies.size() != 0);
    endtask

    task automatic test_directed_basics();
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic [ADDR_W-1:0] addr_c;
        addr_a = '1;
        addr_b = 64'h1;
        addr_c = 64'h8000_0000_0000_0000;
        send_request(KIND_ENTER, '0, 6'd3, 32'd1);
        send_request(KIND_WAKE, '0, 6'd0, 32'd5);
        send_request(KIND_POLL, '1, 6'd63, '1);
        send_request(KIND_LEAVE, addr_a, 6'd5, 32'd0);
        send_request(KIND_ENTER, addr_a, 6'd0, 32'd0);
        send_request(KIND_ENTER, addr_a, 6'd63, '1);
        send_request(KIND_ENTER, addr_b, 6'd0, 32'd0);
        send_request(KIND_WAKE, addr_a, 6'd0, 32'd0);
        send_request(KIND_POLL, '0, 6'd0, 32'd0);
        send_request(KIND_WAKE, addr_a, 6'd0, 32'd1);
        send_request(KIND_POLL, '0, 6'd0, 32'd0);
        send_request(KIND_WAKE, addr_a, 6'd0, '1);
        send_request(KIND_WAKE, addr_c, 6'd0, 32'd7);
        send_request(KIND_LEAVE, '0, 6'd0, 32'd0);
        send_request(KIND_LEAVE, '0, 6'd0, 32'd0);
        send_request(KIND_POLL, '0, 6'd0, 32'd0);
        send_request(KIND_LEAVE, '1, 6'd0, '1);
        // Freed slot 0 is the lowest free one again.
        send_request(KIND_ENTER, addr_c, 6'd0, 32'd0);
        send_request(KIND_LEAVE, '0, 6'd1, 32'd0);
        send_request(KIND_POLL, '0, 6'd1, 32'd0);
        send_request(KIND_LEAVE, '0, 6'd0, 32'd0);
    endtask

    task automatic test_table_full();
        logic [ADDR_W-1:0] extra;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (key_mirror[i] == '0)
                send_request(KIND_ENTER, fresh_address(), IDX_W'($urandom), $urandom);
        end
        extra = fresh_address();
        send_request(KIND_ENTER, extra, 6'd0, 32'd0);
        send_request(KIND_ENTER, key_mirror[SLOTS-1], 6'd0, 32'd0);
        send_request(KIND_WAKE, extra, 6'd0, 32'd3);
        send_request(KIND_WAKE, key_mirror[0], 6'd0, 32'd1);
        // Free one slot in the middle, then reclaim it.
        while (count_mirror[37] != '0)
            send_request(KIND_LEAVE, '0, 6'd37, 32'd0);
        send_request(KIND_ENTER, extra, 6'd0, 32'd0);
        send_request(KIND_ENTER, fresh_address(), 6'd0, 32'd0);
        for (int i = 0; i < SLOTS; i++)
        begin
            while (count_mirror[i] != '0)
                send_request(KIND_LEAVE, {$urandom, $urandom}, IDX_W'(i), $urandom);
        end
    endtask

    task automatic test_random_mix(input int n, input int addr_span, input int enter_pct);
        int                r;
        kind_t             k;
        logic [ADDR_W-1:0] a;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  lim;
        for (int j = 0; j < n; j++)
        begin
            r   = $urandom_range(0, 99);
            a   = addr_pool[$urandom_range(0, addr_span - 1)];
            idx = busy_slot();
            lim = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4);
            if ($urandom_range(0, 24) == 0)
                a = '0;
            if (r < 8)
            begin
                k   = kind_t'($urandom_range(0, 3));
                a   = ($urandom_range(0, 3) == 0) ? '0 : {$urandom, $urandom};
                idx = IDX_W'($urandom);
                lim = $urandom;
            end
            else if (r < 8 + enter_pct)
                k = KIND_ENTER;
            else if (r < 78)
                k = KIND_LEAVE;
            else if (r < 88)
                k = KIND_POLL;
            else
                k = KIND_WAKE;
            if ($urandom_range(0, 59) == 0)
                wait_for_replies();
            send_request(k, a, idx, lim);
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            if (bad_count < 10)
                $display("mismatch on %s: expected %0h, got %0h", what, want, got);
            bad_count++;
        end
    endtask

    // Result side: check each beat against the oldest prediction, stall at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    if (bad_count < 10)
                        $display("result beat with nothing expected, status %0d", status);
                    bad_count++;
                end
                else
                begin
                    oldest_reply = expected_replies.pop_front();
                    check_field("status", 64'(oldest_reply.status), 64'(status));
                    check_field("slot_found", 64'(oldest_reply.slot), 64'(slot_found));
                    check_field("generation", 64'(oldest_reply.gen), 64'(generation));
                    check_field("released", 64'(oldest_reply.released), 64'(released));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 10);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** futex_wait_slot_table: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        kind         <= KIND_POLL;
        word_address <= '0;
        slot_index   <= '0;
        wake_limit   <= '0;
        gaps_on      = 1'b0;
        bad_count    = 0;
        stall_left   = 0;
        idle_cycles  = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            key_mirror[i]   = '0;
            count_mirror[i] = '0;
            gen_mirror[i]   = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            do
                addr_pool[i] = {$urandom, $urandom};
            while (addr_pool[i] == '0);
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        gaps_on = 1'b1;
        test_directed_basics();
        wait_for_replies();
        test_table_full();
        wait_for_replies();
        test_random_mix(300, 8, 35);
        test_random_mix(200, POOL_SIZE, 45);
        gaps_on = 1'b0;
        test_random_mix(150, 16, 35);

        wait_for_replies();
        repeat (SLOTS + 8) @(posedge clk);
        if (bad_count == 0)
            $display("** futex_wait_slot_table: PASSED **");
        else
            $display("** futex_wait_slot_table: FAILED **");
        $finish;
    end

endmodule
